// ===== rtl/core/cam_generation_trigger_top_macros.svh =====
// Assertion macros used by the trigger block's top level.
`ifndef CAM_GENERATION_TRIGGER_TOP_MACROS_SVH
`define CAM_GENERATION_TRIGGER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CGT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trigger check failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define CGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trigger check failed: next-cycle implication");

`endif

// ===== rtl/core/cgt_pkg.sv =====
// Types, constants and register codes of the awareness message trigger.
package cgt_pkg;

	localparam int NOW_W   = 32;
	localparam int HEAD_W  = 12;
	localparam int POS_W   = 24;
	localparam int SPD_W   = 15;
	localparam int IVL_W   = 16;
	localparam int RND_W   = 17;
	localparam int PTHR_W  = 17;
	localparam int PSQ_W   = 2 * PTHR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [NOW_W-1:0]  LOW_FREQ_PERIOD_MS = 32'd500;
	localparam logic [1:0]        LOW_DYN_LIMIT      = 2'd3;
	localparam logic [HEAD_W-1:0] FULL_CIRCLE        = 12'd3600;

	localparam logic [IVL_W-1:0]  RST_MIN_IVL    = 16'd100;
	localparam logic [IVL_W-1:0]  RST_MAX_IVL    = 16'd1000;
	localparam logic [10:0]       RST_HEAD_THR   = 11'd40;
	localparam logic [PTHR_W-1:0] RST_POS_THR    = 17'd400;
	localparam logic [13:0]       RST_SPD_THR    = 14'd50;
	localparam logic [RND_W-1:0]  RST_RND_IVL    = 17'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_IVL   = 3'd0,
		REG_MAX_IVL   = 3'd1,
		REG_HEAD_THR  = 3'd2,
		REG_POS_THR   = 3'd3,
		REG_SPD_THR   = 3'd4,
		REG_RATE_MODE = 3'd5,
		REG_CONG_EN   = 3'd6,
		REG_STARTUP   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_DYN     = 2'd0,
		MODE_FIXED   = 2'd1,
		MODE_RANDOM  = 2'd2,
		MODE_DYN_ALT = 2'd3
	} rate_mode_t;

	typedef enum logic [1:0] {
		RSN_NONE   = 2'd0,
		RSN_RATE   = 2'd1,
		RSN_DYN    = 2'd2,
		RSN_EXPIRY = 2'd3
	} reason_t;

	typedef struct packed {
		logic [NOW_W-1:0]        now_ms;
		logic [HEAD_W-1:0]       heading_now;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [SPD_W-1:0] speed_now;
		logic [IVL_W-1:0]        congestion_interval_ms;
		logic [IVL_W-1:0]        random_extra_ms;
	} item_t;

	typedef struct packed {
		logic [IVL_W-1:0] min_interval_ms;
		logic [IVL_W-1:0] max_interval_ms;
		logic [10:0]      heading_threshold;
		logic [PSQ_W-1:0] position_threshold_sq;
		logic [13:0]      speed_threshold;
		rate_mode_t       rate_mode;
		logic             congestion_enable;
		logic [9:0]       startup_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [NOW_W-1:0]        last_send_time;
		logic [NOW_W-1:0]        last_low_time;
		logic [HEAD_W-1:0]       last_heading;
		logic signed [POS_W-1:0] last_x;
		logic signed [POS_W-1:0] last_y;
		logic signed [SPD_W-1:0] last_speed;
		logic [IVL_W-1:0]        adaptive_interval;
		logic [1:0]              low_dyn_count;
		logic [RND_W-1:0]        next_random_interval;
	} state_t;

	typedef struct packed {
		logic             send_now;
		logic             add_low_freq;
		reason_t          trigger_reason;
		logic [IVL_W-1:0] current_interval_ms;
	} result_t;

endpackage

// ===== rtl/core/cgt_decide.sv =====
// Per-item send decision and next state of the trigger.
module cgt_decide import cgt_pkg::*; (
	input  item_t   item,
	input  cfg_t    cfg,
	input  state_t  st,
	output state_t  st_next,
	output result_t res
);

	logic [IVL_W-1:0]         cong_lo;
	logic [IVL_W-1:0]         cong_clamp;
	logic [RND_W-1:0]         final_min;
	logic                     rnd_reload;
	logic [NOW_W-1:0]         elapsed;
	logic                     gate;
	logic signed [POS_W:0]    dx;
	logic signed [POS_W:0]    dy;
	logic signed [2*POS_W+1:0] dx_sq;
	logic signed [2*POS_W+1:0] dy_sq;
	logic [2*POS_W+1:0]       dist_sq;
	logic                     pos_chg;
	logic signed [SPD_W:0]    ds;
	logic [SPD_W:0]           ds_abs;
	logic                     spd_chg;
	logic [HEAD_W-1:0]        hd;
	logic [HEAD_W-1:0]        hd_mod;
	logic [HEAD_W-1:0]        h_lim;
	logic                     head_chg;
	logic [IVL_W-1:0]         elapsed_cap;
	logic [1:0]               count_inc;
	logic                     low_due;
	logic                     dyn_mode;
	reason_t                  reason;

	// Minimum interval: congestion clamp, stored random value or configured minimum
	assign cong_lo    = (item.congestion_interval_ms < cfg.min_interval_ms) ?
		cfg.min_interval_ms : item.congestion_interval_ms;
	assign cong_clamp = (cong_lo > cfg.max_interval_ms) ? cfg.max_interval_ms : cong_lo;
	assign rnd_reload = !cfg.congestion_enable && (cfg.rate_mode == MODE_RANDOM);
	assign final_min  = cfg.congestion_enable ? {1'b0, cong_clamp} :
		(cfg.rate_mode == MODE_RANDOM) ? st.next_random_interval :
		{1'b0, cfg.min_interval_ms};

	// Time gate
	assign elapsed = item.now_ms - st.last_send_time;
	assign gate    = (elapsed >= {{(NOW_W-RND_W){1'b0}}, final_min})
		&& (item.now_ms > {{(NOW_W-10){1'b0}}, cfg.startup_time_ms});

	// Squared distance against the squared threshold
	assign dx      = {item.pos_x[POS_W-1], item.pos_x} - {st.last_x[POS_W-1], st.last_x};
	assign dy      = {item.pos_y[POS_W-1], item.pos_y} - {st.last_y[POS_W-1], st.last_y};
	assign dx_sq   = dx * dx;
	assign dy_sq   = dy * dy;
	assign dist_sq = {1'b0, dx_sq[2*POS_W:0]} + {1'b0, dy_sq[2*POS_W:0]};
	assign pos_chg = dist_sq > {{(2*POS_W+2-PSQ_W){1'b0}}, cfg.position_threshold_sq};

	// Speed change magnitude
	assign ds      = {item.speed_now[SPD_W-1], item.speed_now}
		- {st.last_speed[SPD_W-1], st.last_speed};
	assign ds_abs  = ds[SPD_W] ? (~ds + 1'b1) : ds;
	assign spd_chg = ds_abs > {{(SPD_W+1-14){1'b0}}, cfg.speed_threshold};

	// Heading change with wrap round the full circle
	assign hd       = (item.heading_now > st.last_heading) ?
		(item.heading_now - st.last_heading) : (st.last_heading - item.heading_now);
	assign hd_mod   = (hd >= FULL_CIRCLE) ? (hd - FULL_CIRCLE) : hd;
	assign h_lim    = {1'b0, cfg.heading_threshold};
	assign head_chg = !((hd_mod <= h_lim) || (hd_mod >= (FULL_CIRCLE - h_lim)));

	assign elapsed_cap = (elapsed < {{(NOW_W-IVL_W){1'b0}}, cfg.max_interval_ms}) ?
		elapsed[IVL_W-1:0] : cfg.max_interval_ms;
	assign count_inc   = (st.low_dyn_count < LOW_DYN_LIMIT) ?
		(st.low_dyn_count + 2'd1) : st.low_dyn_count;
	assign low_due     = (item.now_ms - st.last_low_time) >= LOW_FREQ_PERIOD_MS;
	assign dyn_mode    = (cfg.rate_mode == MODE_DYN) || (cfg.rate_mode == MODE_DYN_ALT);

	// Decide and update the state
	always_comb begin
		st_next          = st;
		reason           = RSN_NONE;
		res.add_low_freq = 1'b0;
		if (rnd_reload) begin
			st_next.next_random_interval = {1'b0, cfg.min_interval_ms}
				+ {1'b0, item.random_extra_ms};
		end
		if (gate) begin
			if (!dyn_mode) begin
				reason = RSN_RATE;
			end else if (head_chg || pos_chg || spd_chg) begin
				reason                    = RSN_DYN;
				st_next.adaptive_interval = elapsed_cap;
				st_next.low_dyn_count     = 2'd0;
			end else if (elapsed >= {{(NOW_W-IVL_W){1'b0}}, st.adaptive_interval}) begin
				reason                = RSN_EXPIRY;
				st_next.low_dyn_count = count_inc;
				if (count_inc >= LOW_DYN_LIMIT) begin
					st_next.adaptive_interval = cfg.max_interval_ms;
				end
			end
		end
		if (reason != RSN_NONE) begin
			st_next.last_x         = item.pos_x;
			st_next.last_y         = item.pos_y;
			st_next.last_speed     = item.speed_now;
			st_next.last_heading   = item.heading_now;
			st_next.last_send_time = item.now_ms;
			if (low_due) begin
				res.add_low_freq      = 1'b1;
				st_next.last_low_time = item.now_ms;
			end
		end
		res.send_now            = (reason != RSN_NONE);
		res.trigger_reason      = reason;
		res.current_interval_ms = st_next.adaptive_interval;
	end

endmodule

// ===== rtl/core/cam_generation_trigger_top.sv =====
// Top level of the awareness message trigger: registers, handshakes and state.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   s_       | in        | s_tvalid/s_tready  | s_tdata, one tick per item
//   m_       | out       | m_tvalid/m_tready  | m_tdata, one decision per item
//   cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// One item per clock sustained while m_tready holds; an item passes the input stage and the output register to m_.
// The critical path is the two 25x25 squares, their sum and compare, through
// to the state registers; state is updated as each item moves to the output.
// Reset clears control and loads the documented state and register values.
// A stalled output holds its item; one further item waits in the input stage.
`include "cam_generation_trigger_top_macros.svh"

module cam_generation_trigger_top import cgt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms[31:0], heading_now[43:32], pos_x[67:44], pos_y[91:68],
	// speed_now[106:92], congestion_interval_ms[122:107], random_extra_ms[138:123]
	input  logic [143:0]          s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// send_now[0], add_low_freq[1], trigger_reason[3:2], current_interval_ms[19:4]
	output logic [23:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	item_t   item_s1;
	item_t   item_in;
	result_t res;
	result_t res_q;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	logic    s_accept;

	// Unpack the input item
	assign item_in.now_ms                 = s_tdata[31:0];
	assign item_in.heading_now            = s_tdata[43:32];
	assign item_in.pos_x                  = s_tdata[67:44];
	assign item_in.pos_y                  = s_tdata[91:68];
	assign item_in.speed_now              = s_tdata[106:92];
	assign item_in.congestion_interval_ms = s_tdata[122:107];
	assign item_in.random_extra_ms        = s_tdata[138:123];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// Configuration registers; the position threshold is kept squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_ms       <= RST_MIN_IVL;
			cfg_q.max_interval_ms       <= RST_MAX_IVL;
			cfg_q.heading_threshold     <= RST_HEAD_THR;
			cfg_q.position_threshold_sq <= {{PTHR_W{1'b0}}, RST_POS_THR}
				* {{PTHR_W{1'b0}}, RST_POS_THR};
			cfg_q.speed_threshold       <= RST_SPD_THR;
			cfg_q.rate_mode             <= MODE_DYN;
			cfg_q.congestion_enable     <= 1'b0;
			cfg_q.startup_time_ms       <= 10'd0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_IVL:   cfg_q.min_interval_ms <= cfg_wdata[IVL_W-1:0];
				REG_MAX_IVL:   cfg_q.max_interval_ms <= cfg_wdata[IVL_W-1:0];
				REG_HEAD_THR:  cfg_q.heading_threshold <= cfg_wdata[10:0];
				REG_POS_THR:   cfg_q.position_threshold_sq <=
					{{PTHR_W{1'b0}}, cfg_wdata[PTHR_W-1:0]}
					* {{PTHR_W{1'b0}}, cfg_wdata[PTHR_W-1:0]};
				REG_SPD_THR:   cfg_q.speed_threshold <= cfg_wdata[13:0];
				REG_RATE_MODE: cfg_q.rate_mode <= rate_mode_t'(cfg_wdata[1:0]);
				REG_CONG_EN:   cfg_q.congestion_enable <= cfg_wdata[0];
				REG_STARTUP:   cfg_q.startup_time_ms <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	cgt_decide u_decide (
		.item    (item_s1),
		.cfg     (cfg_q),
		.st      (st_q),
		.st_next (st_next),
		.res     (res)
	);

	// Tracking state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.last_send_time       <= '0;
			st_q.last_low_time        <= '0 - LOW_FREQ_PERIOD_MS;
			st_q.last_heading         <= '0;
			st_q.last_x               <= '0;
			st_q.last_y               <= '0;
			st_q.last_speed           <= '0;
			st_q.adaptive_interval    <= RST_MAX_IVL;
			st_q.low_dyn_count        <= 2'd0;
			st_q.next_random_interval <= RST_RND_IVL;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, res_q.current_interval_ms, res_q.trigger_reason,
		res_q.add_low_freq, res_q.send_now};

	// Checks
	`CGT_ASSERT_SAME(a_send_matches_reason, clk, arst_n, out_valid_q, res_q.send_now == (res_q.trigger_reason != RSN_NONE))
	`CGT_ASSERT_SAME(a_low_needs_send, clk, arst_n, out_valid_q && res_q.add_low_freq, res_q.send_now)
	`CGT_ASSERT_NEXT(a_send_stamps_time, clk, arst_n, advance && res.send_now, st_q.last_send_time == $past(item_s1.now_ms))
	`CGT_ASSERT_NEXT(a_low_dyn_to_max, clk, arst_n, advance && (res.trigger_reason == RSN_EXPIRY) && (st_next.low_dyn_count == LOW_DYN_LIMIT), st_q.adaptive_interval == $past(cfg_q.max_interval_ms))

endmodule
